// File: hdl/bse_pkg.sv
// Shared types and constants for the braille serpentine emboss sequencer.
// Used by the row tracker, the dot shifter and the top level; no dependencies.
`default_nettype none

package bse_pkg;

   localparam int MAX_COLS_DEF = 30;
   localparam int ROW_DOTS_W   = 30;
   localparam int ROWS_W       = 8;
   localparam int COLS_CFG_W   = 5;
   localparam int CSR_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [ROWS_W-1:0]     ROWS_RESET = 8'd3;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 5'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = 1'b1;

   typedef enum logic [2:0] {
      CMD_SETDIR = 3'd0,
      CMD_STRIKE = 3'd1,
      CMD_XSHORT = 3'd2,
      CMD_XLONG  = 3'd3,
      CMD_YSHORT = 3'd4,
      CMD_YLONG  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETDIR,
      ST_DOT,
      ST_XMOVE,
      ST_YMOVE
   } state_type;

   typedef struct packed {
      logic forward;
      logic last_row;
      logic phase_two;
   } row_info_type;

endpackage

`default_nettype wire

// File: hdl/bse_row_tracker.sv
// Row counter and braille line phase for the emboss sequencer.
// Depends on bse_pkg for widths and the row_info_type struct.
`default_nettype none

module bse_row_tracker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic [bse_pkg::ROWS_W-1:0] rows_in_use,
   output bse_pkg::row_info_type           row_info
);

   localparam int RW = bse_pkg::ROWS_W;

   logic [RW-1:0] row_index_ff, row_index_in;
   logic [1:0]    line_phase_ff, line_phase_in;
   logic [RW-1:0] row_next;
   logic          last_row;

   // rows_in_use of zero wraps to a full 256-row job
   assign last_row = (row_index_ff == RW'(rows_in_use - 1'b1));
   assign row_next = RW'(row_index_ff + 1'b1);

   always_comb begin
      row_index_in  = row_index_ff;
      line_phase_in = line_phase_ff;
      if (advance) begin
         if (last_row || (row_next == '0)) begin
            row_index_in  = '0;
            line_phase_in = 2'd0;
         end else begin
            row_index_in  = row_next;
            line_phase_in = (line_phase_ff >= 2'd2) ? 2'd0 : 2'(line_phase_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff  <= '0;
         line_phase_ff <= 2'd0;
      end else begin
         row_index_ff  <= row_index_in;
         line_phase_ff <= line_phase_in;
      end
   end

   assign row_info.forward   = ~row_index_ff[0];
   assign row_info.last_row  = last_row;
   assign row_info.phase_two = (line_phase_ff == 2'd2);

endmodule

`default_nettype wire

// File: hdl/bse_dot_shifter.sv
// Column shift register: holds one row of dots and presents one dot per step.
// Forward rows shift toward bit 0; reverse rows shift up past the last column tap.
`default_nettype none

module bse_dot_shifter #(
   parameter int MAX_COLS = bse_pkg::MAX_COLS_DEF,
   parameter int COL_W    = $clog2(MAX_COLS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic                           shift,
   input  wire logic                           forward,
   input  wire logic [bse_pkg::ROW_DOTS_W-1:0] row_dots,
   input  wire logic [COL_W-1:0]               last_col,
   output logic                                dot
);

   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [MAX_COLS-1:0] shift_ff, shift_in;
   logic [MAX_COLS-1:0] load_vec;
   logic                rev_dot;

   // columns past the input width read as empty
   for (genvar i = 0; i < MAX_COLS; i++) begin : g_load
      if (i < bse_pkg::ROW_DOTS_W) begin : g_dot
         assign load_vec[i] = row_dots[i];
      end else begin : g_pad
         assign load_vec[i] = 1'b0;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (load) begin
         shift_in = load_vec;
      end else if (shift) begin
         shift_in = forward ? (shift_ff >> 1) : (shift_ff << 1);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rev_dot = (last_col < COL_W'(MAX_COLS)) ? shift_ff[last_col[IDX_W-1:0]] : 1'b0;
   assign dot     = forward ? shift_ff[0] : rev_dot;

endmodule

`default_nettype wire

// File: hdl/braille_serpentine_emboss_sequencer.sv
// Braille serpentine emboss sequencer: one row of dots in, its actuator commands out.
// Depends on bse_pkg, bse_row_tracker and bse_dot_shifter.
//
// Each accepted row is held in a column shift register that advances one column per
// dot step, and a sequencer emits one command per cycle while no result waits on
// rsp_ready (a dot step with a clear dot emits none): set direction, then for every
// column a dot step (strike when the dot is set) and an X move between columns, then a
// Y move unless the row is the last of the job. The next row is taken once the
// current one has issued its final command; that command may still wait in the output
// register while the new row is accepted. rsp_last marks the final command of a row
// and rsp_job_done the final command of the last configured row.
`default_nettype none

module braille_serpentine_emboss_sequencer #(
   parameter int MAX_COLS = bse_pkg::MAX_COLS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bse_pkg::ROW_DOTS_W-1:0]  req_row_dots,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_command,
   output logic                                 rsp_forward,
   output logic                                 rsp_last,
   output logic                                 rsp_job_done,
   input  wire logic                            csr_write,
   input  wire logic [bse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bse_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_COLS + 1);
   localparam int CW    = bse_pkg::COLS_CFG_W;
   localparam int RW    = bse_pkg::ROWS_W;

   logic [RW-1:0] rows_cfg_ff;
   logic [CW-1:0] cols_cfg_ff;

   bse_pkg::state_type    state_ff, state_in;
   bse_pkg::row_info_type row_info;
   bse_pkg::cmd_type      cmd, rsp_cmd_ff;

   logic [COL_W-1:0] cols_sat, cols_ff, cols_m1_ff, pos_ff, pos_in, pos_next;
   logic             forward_ff, last_row_ff, phase_two_ff;
   logic             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_job_done_ff;
   logic             rsp_forward_ff;
   logic             accept, adv, emit, last, shift_en, dot;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= bse_pkg::ROWS_RESET;
         cols_cfg_ff <= bse_pkg::COLS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            bse_pkg::CSR_ROWS_IN_USE: rows_cfg_ff <= csr_wdata[RW-1:0];
            bse_pkg::CSR_COLS_IN_USE: cols_cfg_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign cols_sat = (cols_cfg_ff > CW'(MAX_COLS)) ? COL_W'(MAX_COLS) : COL_W'(cols_cfg_ff);

   assign req_ready = (state_ff == bse_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pos_next  = COL_W'(pos_ff + 1'b1);

   bse_row_tracker u_rows (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .rows_in_use (rows_cfg_ff),
      .row_info    (row_info)
   );

   bse_dot_shifter #(
      .MAX_COLS (MAX_COLS),
      .COL_W    (COL_W)
   ) u_dots (
      .clock    (clock),
      .load     (accept),
      .shift    (shift_en),
      .forward  (forward_ff),
      .row_dots (req_row_dots),
      .last_col (cols_m1_ff),
      .dot      (dot)
   );

   // row context, captured per transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cols_ff      <= cols_sat;
         cols_m1_ff   <= COL_W'(cols_sat - 1'b1);
         forward_ff   <= row_info.forward;
         last_row_ff  <= row_info.last_row;
         phase_two_ff <= row_info.phase_two;
      end
   end

   // command sequencer; last is found ahead from the next dot
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      emit     = 1'b0;
      cmd      = bse_pkg::CMD_SETDIR;
      last     = 1'b0;
      shift_en = 1'b0;
      unique case (state_ff)
         bse_pkg::ST_IDLE: begin
            pos_in = '0;
            if (req_valid) begin
               state_in = bse_pkg::ST_SETDIR;
            end
         end
         bse_pkg::ST_SETDIR: begin
            if (adv) begin
               emit = 1'b1;
               cmd  = bse_pkg::CMD_SETDIR;
               last = last_row_ff && ((cols_ff == '0) || ((cols_ff == COL_W'(1)) && !dot));
               if (last) begin
                  state_in = bse_pkg::ST_IDLE;
               end else if (cols_ff == '0) begin
                  state_in = bse_pkg::ST_YMOVE;
               end else begin
                  state_in = bse_pkg::ST_DOT;
               end
            end
         end
         bse_pkg::ST_DOT: begin
            if (adv) begin
               emit     = dot;
               cmd      = bse_pkg::CMD_STRIKE;
               shift_en = 1'b1;
               last     = last_row_ff && (pos_ff == cols_m1_ff);
               if (pos_ff == cols_m1_ff) begin
                  state_in = last_row_ff ? bse_pkg::ST_IDLE : bse_pkg::ST_YMOVE;
               end else begin
                  state_in = bse_pkg::ST_XMOVE;
               end
            end
         end
         bse_pkg::ST_XMOVE: begin
            if (adv) begin
               emit   = 1'b1;
               cmd    = pos_ff[0] ? bse_pkg::CMD_XLONG : bse_pkg::CMD_XSHORT;
               last   = last_row_ff && (pos_next == cols_m1_ff) && !dot;
               pos_in = pos_next;
               state_in = last ? bse_pkg::ST_IDLE : bse_pkg::ST_DOT;
            end
         end
         bse_pkg::ST_YMOVE: begin
            if (adv) begin
               emit     = 1'b1;
               cmd      = phase_two_ff ? bse_pkg::CMD_YLONG : bse_pkg::CMD_YSHORT;
               last     = 1'b1;
               state_in = bse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_cmd_ff      <= cmd;
         rsp_last_ff     <= last;
         rsp_job_done_ff <= last && last_row_ff;
         rsp_forward_ff  <= forward_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_command  = rsp_cmd_ff;
   assign rsp_forward  = rsp_forward_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_job_done = rsp_job_done_ff;

`ifndef SYNTHESIS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_job_done_ff |-> rsp_last_ff)
      else $error("job_done without last");

   a_ymove_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_cmd_ff == bse_pkg::CMD_YSHORT) || (rsp_cmd_ff == bse_pkg::CMD_YLONG))
      |-> rsp_last_ff && !rsp_job_done_ff)
      else $error("Y move not final or on last row");

   a_accept_starts_row: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == bse_pkg::ST_SETDIR)
      else $error("accepted row did not start with set direction");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bse_pkg::ST_DOT) || (state_ff == bse_pkg::ST_XMOVE) |-> pos_ff < cols_ff)
      else $error("column position beyond columns in use");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire
